// ----- src/circle_vertex_generator_assert.svh -----
// Assertion macros for the circle vertex generator.
`ifndef CIRCLE_VERTEX_GENERATOR_ASSERT_SVH
`define CIRCLE_VERTEX_GENERATOR_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define CVG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, also checked during reset.
`define CVG_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/cvg_pkg.sv -----
// Shared types, constants and the arctangent table of the circle vertex generator.
package cvg_pkg;
  localparam int MAX_SEGMENTS  = 4096;
  localparam int CORDIC_STAGES = 18;
  localparam int PHASE_BITS    = 32;
  localparam int CNT_W         = 13;
  localparam int CW            = 34;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS   = 3'd2;
  localparam logic [2:0] REG_SEGMENTS = 3'd3;

  typedef struct packed {
    logic                   valid;
    logic                   err;
    logic                   ctr;
    logic [CNT_W-1:0]       rem;
    logic [PHASE_BITS-1:0]  quo;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   z;
    logic [1:0]             quad;
  } item_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic signed [CW-1:0] atan_turns(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0: v = 34'sd536870912;   5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;   5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;    5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10679838;    5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;     5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;     5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;     5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;       5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;        5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;        5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;         5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;         5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;          5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// ----- src/circle_vertex_generator.sv -----
// Top level: circle vertex generator, a divider chain feeding a CORDIC chain.
//
//  channel  | valid        | stall        | payload
//  index    | index_valid  | index_stall  | vertex_index
//  vertex   | vertex_valid | vertex_stall | vertex_x, vertex_y, index_error
//
// One item per cycle enters while the chain is not stalled; the path has one input stage, 32 division
// cells (one phase bit each), 18 CORDIC cells, one multiply stage, one output stage.
// Reset clears only the valid bits and loads the register reset values.
// A stalled result freezes the whole chain; index_stall follows it.
module circle_vertex_generator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     index_valid,
  output logic                     index_stall,
  input  logic [12:0]              vertex_index,
  output logic                     vertex_valid,
  input  logic                     vertex_stall,
  output logic signed [31:0]       vertex_x,
  output logic signed [31:0]       vertex_y,
  output logic                     index_error
);
  localparam int NDIV = cvg_pkg::PHASE_BITS;
  localparam int NCOR = cvg_pkg::CORDIC_STAGES;

  logic signed [31:0]       center_x;
  logic signed [31:0]       center_y;
  logic [30:0]              radius;
  logic [12:0]              segment_count;
  logic [12:0]              n_sat;
  logic                     en;

  cvg_pkg::item_t           in_item;
  cvg_pkg::item_t           div_q [NDIV+1];
  cvg_pkg::item_t           cor_q [NCOR+1];

  logic signed [cvg_pkg::CW-1:0] cx;
  logic signed [cvg_pkg::CW-1:0] cy;
  logic signed [cvg_pkg::CW-1:0] tc;
  logic signed [cvg_pkg::CW-1:0] ts;
  logic signed [63:0]       prod_x;
  logic signed [63:0]       prod_y;
  logic                     mul_valid;
  logic                     mul_err;
  logic                     mul_ctr;
  logic signed [63:0]       sum_x;
  logic signed [63:0]       sum_y;

  assign en          = !(vertex_valid && vertex_stall);
  assign index_stall = !en;
  assign n_sat = (segment_count > 13'(cvg_pkg::MAX_SEGMENTS)) ?
                 13'(cvg_pkg::MAX_SEGMENTS) : segment_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      radius        <= 31'd65536;
      segment_count <= 13'd72;
    end else if (cfg_write) begin
      case (cfg_index)
        cvg_pkg::REG_CENTER_X: center_x      <= cfg_data;
        cvg_pkg::REG_CENTER_Y: center_y      <= cfg_data;
        cvg_pkg::REG_RADIUS:   radius        <= cfg_data[30:0];
        cvg_pkg::REG_SEGMENTS: segment_count <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item       = '0;
    in_item.valid = index_valid;
    in_item.err   = vertex_index > n_sat;
    in_item.ctr   = (vertex_index == '0) || (vertex_index > n_sat);
    in_item.rem   = (vertex_index == '0) ? '0 : vertex_index - 13'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_q[0].valid <= 1'b0;
    end else if (en) begin
      div_q[0].valid <= in_item.valid;
    end
    if (en) begin
      div_q[0].err  <= in_item.err;
      div_q[0].ctr  <= in_item.ctr;
      div_q[0].rem  <= in_item.rem;
      div_q[0].quo  <= in_item.quo;
      div_q[0].x    <= in_item.x;
      div_q[0].y    <= in_item.y;
      div_q[0].z    <= in_item.z;
      div_q[0].quad <= in_item.quad;
    end
  end

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    cvg_div_cell u_div (
      .clk(clk), .rst(rst), .en(en), .divisor(n_sat),
      .din(div_q[g]), .dout(div_q[g+1])
    );
  end

  // The phase's top bits pick the quadrant; the rest seeds the rotation.
  always_comb begin
    cor_q[0]      = div_q[NDIV];
    cor_q[0].x    = cvg_pkg::GAIN_Q30;
    cor_q[0].y    = '0;
    cor_q[0].z    = cvg_pkg::CW'({2'b00, div_q[NDIV].quo[29:0]});
    cor_q[0].quad = div_q[NDIV].quo[31:30];
  end

  for (genvar g = 0; g < NCOR; g++) begin : g_cor
    cvg_cordic_cell u_cor (
      .clk(clk), .rst(rst), .en(en), .shift(5'(g)),
      .din(cor_q[g]), .dout(cor_q[g+1])
    );
  end

  always_comb begin
    cx = cor_q[NCOR].x;
    cy = cor_q[NCOR].y;
    if (cx > cvg_pkg::ONE_Q30) cx = cvg_pkg::ONE_Q30;
    if (cx < -cvg_pkg::ONE_Q30) cx = -cvg_pkg::ONE_Q30;
    if (cy > cvg_pkg::ONE_Q30) cy = cvg_pkg::ONE_Q30;
    if (cy < -cvg_pkg::ONE_Q30) cy = -cvg_pkg::ONE_Q30;
    case (cor_q[NCOR].quad)
      2'd0:    begin tc = cx;  ts = cy;  end
      2'd1:    begin tc = -cy; ts = cx;  end
      2'd2:    begin tc = -cx; ts = -cy; end
      default: begin tc = cy;  ts = -cx; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= cor_q[NCOR].valid;
    end
    if (en) begin
      mul_err <= cor_q[NCOR].err;
      mul_ctr <= cor_q[NCOR].ctr;
      prod_x  <= $signed({1'b0, radius}) * $signed(tc[31:0]);
      prod_y  <= $signed({1'b0, radius}) * $signed(ts[31:0]);
    end
  end

  always_comb begin
    sum_x = 64'(center_x) + ((prod_x + 64'sd536870912) >>> 30);
    sum_y = 64'(center_y) + ((prod_y + 64'sd536870912) >>> 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (en) begin
      vertex_valid <= mul_valid;
    end
    if (en) begin
      index_error <= mul_err;
      if (mul_ctr) begin
        vertex_x <= center_x;
        vertex_y <= center_y;
      end else begin
        vertex_x <= (sum_x > 64'sd2147483647) ? 32'sh7fffffff :
                    (sum_x < -64'sd2147483648) ? 32'sh80000000 : sum_x[31:0];
        vertex_y <= (sum_y > 64'sd2147483647) ? 32'sh7fffffff :
                    (sum_y < -64'sd2147483648) ? 32'sh80000000 : sum_y[31:0];
      end
    end
  end

`include "circle_vertex_generator_assert.svh"
  `CVG_ASSERT_NEXT(a_reset_empty, clk, rst, !vertex_valid)
  `CVG_ASSERT_IMPL(a_err_center, clk, rst, vertex_valid && index_error, vertex_x == center_x && vertex_y == center_y)
  `CVG_ASSERT_IMPL(a_zero_radius, clk, rst, vertex_valid && radius == '0, vertex_x == center_x)
endmodule

// ----- src/cvg_div_cell.sv -----
// One restoring-division cell: produces one phase bit per item.
module cvg_div_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [cvg_pkg::CNT_W-1:0]  divisor,
  input  cvg_pkg::item_t             din,
  output cvg_pkg::item_t             dout
);
  logic [cvg_pkg::CNT_W:0] r2;
  logic                    ge;
  cvg_pkg::item_t          item_next;

  always_comb begin
    r2 = {din.rem, 1'b0};
    ge = r2 >= {1'b0, divisor};
    item_next = din;
    item_next.rem = ge ? cvg_pkg::CNT_W'(r2 - {1'b0, divisor}) : r2[cvg_pkg::CNT_W-1:0];
    item_next.quo = {din.quo[cvg_pkg::PHASE_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= item_next.valid;
    end
    if (en) begin
      dout.err  <= item_next.err;
      dout.ctr  <= item_next.ctr;
      dout.rem  <= item_next.rem;
      dout.quo  <= item_next.quo;
      dout.x    <= item_next.x;
      dout.y    <= item_next.y;
      dout.z    <= item_next.z;
      dout.quad <= item_next.quad;
    end
  end
endmodule

// ----- src/cvg_cordic_cell.sv -----
// One CORDIC rotation cell.
module cvg_cordic_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [4:0]      shift,
  input  cvg_pkg::item_t  din,
  output cvg_pkg::item_t  dout
);
  logic signed [cvg_pkg::CW-1:0] dx;
  logic signed [cvg_pkg::CW-1:0] dy;
  logic signed [cvg_pkg::CW-1:0] a;
  cvg_pkg::item_t                item_next;

  always_comb begin
    dx = din.y >>> shift;
    dy = din.x >>> shift;
    a  = cvg_pkg::atan_turns(shift);
    item_next = din;
    if (!din.z[cvg_pkg::CW-1]) begin
      item_next.x = din.x - dx;
      item_next.y = din.y + dy;
      item_next.z = din.z - a;
    end else begin
      item_next.x = din.x + dx;
      item_next.y = din.y - dy;
      item_next.z = din.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= item_next.valid;
    end
    if (en) begin
      dout.err  <= item_next.err;
      dout.ctr  <= item_next.ctr;
      dout.rem  <= item_next.rem;
      dout.quo  <= item_next.quo;
      dout.x    <= item_next.x;
      dout.y    <= item_next.y;
      dout.z    <= item_next.z;
      dout.quad <= item_next.quad;
    end
  end
endmodule
